// ===== hdl/obfp_pkg.sv =====
// Shared types and constants for the object block frame parser.
package obfp_pkg;

    // Word codes seen on the camera link
    localparam logic [15:0] SYNC_WORD    = 16'haa55;
    localparam logic [15:0] SYNC_CC_WORD = 16'haa56;
    localparam logic [15:0] REORDER_WORD = 16'h55aa;
    localparam logic [15:0] IDLE_WORD    = 16'hffff;
    localparam logic [15:0] ZERO_WORD    = 16'h0000;

    // Field words per block
    localparam logic [2:0] NORMAL_FIELDS = 3'd5;
    localparam logic [2:0] CC_FIELDS     = 3'd6;

    // Hard ceiling on good blocks per frame, and the reset value of max_blocks
    localparam logic [7:0] BLOCK_LIMIT     = 8'd128;
    localparam logic [7:0] MAX_BLOCKS_RST  = 8'd128;

    // Result kinds
    localparam logic KIND_BLOCK     = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // Master-side stream widths and tdata layout (lowest bit up)
    localparam int TDATA_W   = 112;
    localparam int TUSER_W   = 2;
    localparam int OK_BIT    = 0;
    localparam int SIG_LSB   = 1;
    localparam int XPOS_LSB  = 17;
    localparam int YPOS_LSB  = 33;
    localparam int BOXW_LSB  = 49;
    localparam int BOXH_LSB  = 65;
    localparam int ROT_LSB   = 81;
    localparam int GOOD_LSB  = 97;
    localparam int USED_W    = 105;
    localparam int KIND_BIT  = 0;
    localparam int CC_BIT    = 1;

    typedef enum logic [3:0] {
        PH_HUNT      = 4'b0001,
        PH_CHECKSUM  = 4'b0010,
        PH_FIELDS    = 4'b0100,
        PH_SEPARATOR = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic        color_code;
        logic        checksum_ok;
        logic [15:0] signature;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] rotation;
        logic [7:0]  good_count;
    } t_result;

endpackage

// ===== hdl/object_block_frame_parser_unit.sv =====
// Top level of the object block frame parser: byte pairing, frame parsing, output stage.
//
// Object block frame parser. Takes one received camera byte per transaction on
// the s_axis side, pairs bytes into little-endian 16-bit words, hunts for the
// double sync (0xaa55 0xaa55 for a normal frame, 0xaa55 0xaa56 for a color-code
// frame) and then parses blocks of one checksum word followed by five (normal)
// or six (color-code) field words. Each block leaves as one m_axis transaction
// with its checksum_ok flag and the running count of good blocks; a frame end
// leaves as a transaction with tuser kind set and the final good count. Rate:
// one byte per clock cycle while s_axis_tready is high; each byte's update is
// one pass of logic from the parser state registers into the output registers,
// so a result is registered the cycle after the byte that completes it. The
// output is a result register plus one skid entry; s_axis_tready drops only
// while both hold results that m_axis has not taken. Results arrive at most one
// per word, so at full rate with a free-running m_axis_tready the input never
// stalls. max_blocks is written through i_cfg_wr_en/i_cfg_wr_data; zero acts as
// one, and values above 128 act as 128. Write it only while the stream is idle.
module object_block_frame_parser_unit
    import obfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: max_blocks
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    // Received bytes
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    // Parsed results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] checksum_ok, [16:1] signature, [32:17] x_pos, [48:33] y_pos,
    // [64:49] box_width, [80:65] box_height, [96:81] rotation,
    // [104:97] good_count, [111:105] zero
    output logic [TDATA_W-1:0]   m_axis_tdata,
    // [0] kind, [1] color_code
    output logic [TUSER_W-1:0]   m_axis_tuser
);

    // Configuration register
    logic [7:0]  r_max_blocks;

    // Byte pairing state
    logic        r_high_next, n_high_next;
    logic [7:0]  r_low_hold,  n_low_hold;
    logic        r_drop_next, n_drop_next;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [15:0] r_prev_word, n_prev_word;
    logic        r_cc_frame, n_cc_frame;
    logic [2:0]  r_field_idx, n_field_idx;
    logic [15:0] r_exp_sum, n_exp_sum;
    logic [15:0] r_run_sum, n_run_sum;
    logic [7:0]  r_block_cnt, n_block_cnt;
    logic [15:0] r_field_store [6];

    // Output stage: result register and skid entry
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        w_accept;
    logic        w_take;
    logic [15:0] w_word;
    logic        w_word_valid;
    logic        w_store_en;
    logic [7:0]  w_limit;
    logic        w_is_sync;
    logic [15:0] w_sum;
    logic [2:0]  w_idx_inc;
    logic [2:0]  w_nfields;
    logic        w_sum_ok;
    logic [15:0] w_fld [5];
    logic        n_res_valid;
    t_result     n_res;

    // Hold off input only when both output slots are occupied
    assign s_axis_tready = i_rst_n && !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_take        = r_out_valid && m_axis_tready;

    // Effective block limit: zero acts as one, clamp at the hard ceiling
    always_comb begin
        if (r_max_blocks == 8'd0) begin
            w_limit = 8'd1;
        end else if (r_max_blocks > BLOCK_LIMIT) begin
            w_limit = BLOCK_LIMIT;
        end else begin
            w_limit = r_max_blocks;
        end
    end

    assign w_word    = {s_axis_tdata, r_low_hold};
    assign w_is_sync = (w_word == SYNC_WORD) || (w_word == SYNC_CC_WORD);
    assign w_sum     = r_run_sum + w_word;
    assign w_idx_inc = r_field_idx + 3'd1;
    assign w_nfields = r_cc_frame ? CC_FIELDS : NORMAL_FIELDS;
    assign w_sum_ok  = (w_sum == r_exp_sum);

    // Field words as they stand once the current word is stored
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_fld[i] = (r_field_idx == 3'(i)) ? w_word : r_field_store[i];
        end
    end

    // Byte pairing: drop a byte after a reorder word, else pair low then high
    always_comb begin
        n_high_next  = r_high_next;
        n_low_hold   = r_low_hold;
        n_drop_next  = r_drop_next;
        w_word_valid = 1'b0;
        if (w_accept) begin
            if (r_drop_next) begin
                n_drop_next = 1'b0;
            end else if (!r_high_next) begin
                n_low_hold  = s_axis_tdata;
                n_high_next = 1'b1;
            end else begin
                n_high_next  = 1'b0;
                w_word_valid = 1'b1;
            end
        end

        // Parser defaults: hold state, no result
        n_phase     = r_phase;
        n_prev_word = r_prev_word;
        n_cc_frame  = r_cc_frame;
        n_field_idx = r_field_idx;
        n_exp_sum   = r_exp_sum;
        n_run_sum   = r_run_sum;
        n_block_cnt = r_block_cnt;
        w_store_en  = 1'b0;
        n_res_valid = 1'b0;
        n_res       = '0;
        n_res.kind  = KIND_FRAME_END;
        n_res.good_count = r_block_cnt;

        if (w_word_valid) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_word == ZERO_WORD && r_prev_word == ZERO_WORD) begin
                        n_prev_word = IDLE_WORD;
                    end else if (r_prev_word == SYNC_WORD && w_is_sync) begin
                        n_cc_frame  = (w_word == SYNC_CC_WORD);
                        n_block_cnt = 8'd0;
                        n_phase     = PH_CHECKSUM;
                    end else begin
                        if (w_word == REORDER_WORD) begin
                            n_drop_next = 1'b1;
                        end
                        n_prev_word = w_word;
                    end
                end
                PH_CHECKSUM: begin
                    if (w_is_sync) begin
                        // Frame ends, next one starts at once
                        n_res_valid = 1'b1;
                        n_cc_frame  = (w_word == SYNC_CC_WORD);
                        n_block_cnt = 8'd0;
                    end else if (w_word == ZERO_WORD) begin
                        n_res_valid = 1'b1;
                        n_phase     = PH_HUNT;
                        n_prev_word = IDLE_WORD;
                    end else begin
                        n_exp_sum   = w_word;
                        n_run_sum   = 16'd0;
                        n_field_idx = 3'd0;
                        n_phase     = PH_FIELDS;
                    end
                end
                PH_FIELDS: begin
                    w_store_en  = 1'b1;
                    n_run_sum   = w_sum;
                    n_field_idx = w_idx_inc;
                    if (w_idx_inc >= w_nfields) begin
                        n_block_cnt          = r_block_cnt + {7'd0, w_sum_ok};
                        n_res_valid          = 1'b1;
                        n_res.kind           = KIND_BLOCK;
                        n_res.color_code     = r_cc_frame;
                        n_res.checksum_ok    = w_sum_ok;
                        n_res.signature      = w_fld[0];
                        n_res.x_pos          = w_fld[1];
                        n_res.y_pos          = w_fld[2];
                        n_res.box_width      = w_fld[3];
                        n_res.box_height     = w_fld[4];
                        n_res.rotation       = r_cc_frame ? w_word : 16'd0;
                        n_res.good_count     = n_block_cnt;
                        n_phase              = PH_SEPARATOR;
                    end
                end
                PH_SEPARATOR: begin
                    if (w_is_sync) begin
                        n_cc_frame = (w_word == SYNC_CC_WORD);
                    end
                    if (w_is_sync && r_block_cnt < w_limit) begin
                        n_phase = PH_CHECKSUM;
                    end else begin
                        n_res_valid = 1'b1;
                        n_phase     = PH_HUNT;
                        n_prev_word = IDLE_WORD;
                    end
                end
                default: begin
                    n_phase     = PH_HUNT;
                    n_prev_word = IDLE_WORD;
                end
            endcase
        end
    end

    // Configuration and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_blocks <= MAX_BLOCKS_RST;
            r_high_next  <= 1'b0;
            r_low_hold   <= 8'd0;
            r_drop_next  <= 1'b0;
            r_phase      <= PH_HUNT;
            r_prev_word  <= IDLE_WORD;
            r_cc_frame   <= 1'b0;
            r_field_idx  <= 3'd0;
            r_exp_sum    <= 16'd0;
            r_run_sum    <= 16'd0;
            r_block_cnt  <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_blocks <= i_cfg_wr_data;
            end
            r_high_next <= n_high_next;
            r_low_hold  <= n_low_hold;
            r_drop_next <= n_drop_next;
            r_phase     <= n_phase;
            r_prev_word <= n_prev_word;
            r_cc_frame  <= n_cc_frame;
            r_field_idx <= n_field_idx;
            r_exp_sum   <= n_exp_sum;
            r_run_sum   <= n_run_sum;
            r_block_cnt <= n_block_cnt;
        end
    end

    // Field words of the current block; never read before written
    always_ff @(posedge i_clk) begin
        if (w_store_en) begin
            for (int i = 0; i < 6; i++) begin
                if (r_field_idx == 3'(i)) begin
                    r_field_store[i] <= w_word;
                end
            end
        end
    end

    // Output stage: advance the skid entry when the result register frees up,
    // park a new result in the skid entry when the result register is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= n_res_valid;
                end
            end else if (n_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (n_res_valid) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.color_code, r_out.kind};
    assign m_axis_tdata  = {{(TDATA_W - USED_W){1'b0}},
                            r_out.good_count,
                            r_out.rotation,
                            r_out.box_height,
                            r_out.box_width,
                            r_out.y_pos,
                            r_out.x_pos,
                            r_out.signature,
                            r_out.checksum_ok};

endmodule

// ===== hdl/obfp_checker.sv =====
// Port-level checker for the object block frame parser, bound to the top level.
module obfp_checker
    import obfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [TDATA_W-1:0]   m_axis_tdata,
    input  logic [TUSER_W-1:0]   m_axis_tuser
);

    // A stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A frame end carries only the good count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[KIND_BIT] |->
            m_axis_tdata[ROT_LSB+15:0] == '0 && !m_axis_tuser[CC_BIT])
        else $error("frame end carries block payload");

    // A normal block has zero rotation
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[KIND_BIT] && !m_axis_tuser[CC_BIT] |->
            m_axis_tdata[ROT_LSB+15:ROT_LSB] == 16'd0)
        else $error("normal block with nonzero rotation");

    // A good block is counted, and the count stays within the ceiling
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[KIND_BIT] && m_axis_tdata[OK_BIT] |->
            m_axis_tdata[GOOD_LSB+7:GOOD_LSB] != 8'd0 &&
            m_axis_tdata[GOOD_LSB+7:GOOD_LSB] <= BLOCK_LIMIT)
        else $error("good block count out of range");

    // Padding bits stay zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:USED_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind object_block_frame_parser_unit obfp_checker u_obfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
